// ===== design/psci_power_call_handler_core_assert.svh =====
// Assertion macros for the PSCI call handler.
`ifndef PSCI_POWER_CALL_HANDLER_CORE_ASSERT_SVH
`define PSCI_POWER_CALL_HANDLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSCI_ASSERT_NOW(label, clk_i, rst_n_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSCI_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== design/psci_pch_pkg.sv =====
`default_nettype none

package psci_pch_pkg;

	localparam int MAX_CORES_DEF = 8;
	localparam int AFF_W         = 8;
	localparam int NUM_CORES_W   = 4;
	localparam int FID_W         = 32;
	localparam int RV_W          = 33;
	localparam int CORE_W        = 3;
	localparam int ADDR_W        = 64;

	localparam logic [NUM_CORES_W-1:0] NUM_CORES_RST = 4'd1;

	localparam logic [FID_W-1:0] FN_VERSION      = 32'h8400_0000;
	localparam logic [FID_W-1:0] FN_CPU_OFF      = 32'h8400_0002;
	localparam logic [FID_W-1:0] FN_CPU_ON_32    = 32'h8400_0003;
	localparam logic [FID_W-1:0] FN_CPU_ON_64    = 32'hC400_0003;
	localparam logic [FID_W-1:0] FN_AFF_INFO_32  = 32'h8400_0004;
	localparam logic [FID_W-1:0] FN_AFF_INFO_64  = 32'hC400_0004;
	localparam logic [FID_W-1:0] FN_MIGRATE_TYPE = 32'h8400_0006;
	localparam logic [FID_W-1:0] FN_SYS_OFF      = 32'h8400_0008;
	localparam logic [FID_W-1:0] FN_SYS_RESET    = 32'h8400_0009;
	localparam logic [FID_W-1:0] FN_FEATURES     = 32'h8400_000A;

	localparam logic signed [RV_W-1:0] RV_SUCCESS    = 33'sd0;
	localparam logic signed [RV_W-1:0] RV_NOT_SUPP   = -33'sd1;
	localparam logic signed [RV_W-1:0] RV_INVALID    = -33'sd2;
	localparam logic signed [RV_W-1:0] RV_ALREADY_ON = -33'sd4;
	localparam logic signed [RV_W-1:0] RV_VERSION    = 33'sd65537;
	localparam logic signed [RV_W-1:0] RV_AFF_ON     = 33'sd0;
	localparam logic signed [RV_W-1:0] RV_AFF_OFF    = 33'sd1;
	localparam logic signed [RV_W-1:0] RV_MIGRATE    = 33'sd2;

	typedef struct packed {
		logic load;
	} psci_cmd_t;

	function automatic logic feature_known(input logic [FID_W-1:0] fid);
		logic known;
		unique case (fid)
			FN_VERSION, FN_CPU_ON_32, FN_CPU_ON_64, FN_CPU_OFF,
			FN_AFF_INFO_32, FN_AFF_INFO_64, FN_SYS_OFF,
			FN_SYS_RESET, FN_FEATURES: known = 1'b1;
			default:                     known = 1'b0;
		endcase
		return known;
	endfunction

endpackage

`default_nettype wire

// ===== design/psci_pch_ctrl.sv =====
`default_nettype none

module psci_pch_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output psci_pch_pkg::psci_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign out_valid = (state_q == ST_FULL);
	assign in_stall  = (state_q == ST_FULL) && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cmd.load  = accept;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (accept) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (!out_stall && !accept) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/psci_pch_dp.sv =====
`default_nettype none

module psci_pch_dp #(
	parameter int MAX_CORES = psci_pch_pkg::MAX_CORES_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire psci_pch_pkg::psci_cmd_t                cmd,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [psci_pch_pkg::NUM_CORES_W-1:0]   cfg_wr_data,
	input  wire logic [psci_pch_pkg::FID_W-1:0]         function_id,
	input  wire logic [psci_pch_pkg::CORE_W-1:0]        caller_core,
	input  wire logic [psci_pch_pkg::FID_W-1:0]         argument_one,
	input  wire logic [psci_pch_pkg::ADDR_W-1:0]        entry_address,
	input  wire logic [psci_pch_pkg::ADDR_W-1:0]        context_value,
	output logic                                        handled,
	output logic signed [psci_pch_pkg::RV_W-1:0]        return_value,
	output logic                                        start_valid,
	output logic [psci_pch_pkg::CORE_W-1:0]             start_core,
	output logic [psci_pch_pkg::ADDR_W-1:0]             start_entry,
	output logic [psci_pch_pkg::ADDR_W-1:0]             start_context
);

	localparam int CIW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int TGT_W = psci_pch_pkg::AFF_W + 1;

	logic [psci_pch_pkg::NUM_CORES_W-1:0] num_cores_q;
	logic [MAX_CORES-1:0]                 core_on_q;
	logic [MAX_CORES-1:0]                 core_on_d;

	logic [psci_pch_pkg::AFF_W-1:0]       target;
	logic [TGT_W-1:0]                     target_ext;
	logic [CIW-1:0]                       target_idx;
	logic [CIW-1:0]                       caller_idx;
	logic                                 target_ok;
	logic                                 caller_ok;
	logic                                 target_on;

	logic                                 handled_d;
	logic signed [psci_pch_pkg::RV_W-1:0] rv_d;
	logic                                 sv_d;

	logic                                 handled_q;
	logic signed [psci_pch_pkg::RV_W-1:0] rv_q;
	logic                                 sv_q;
	logic [psci_pch_pkg::CORE_W-1:0]      sc_q;
	logic [psci_pch_pkg::ADDR_W-1:0]      se_q;
	logic [psci_pch_pkg::ADDR_W-1:0]      sx_q;

	assign target     = argument_one[psci_pch_pkg::AFF_W-1:0];
	assign target_ext = TGT_W'(target);
	assign target_idx = CIW'(target);
	assign caller_idx = CIW'(caller_core);
	assign target_ok  = (target_ext < TGT_W'(num_cores_q)) && (32'(target) < MAX_CORES);
	assign caller_ok  = 32'(caller_core) < MAX_CORES;
	assign target_on  = core_on_q[target_idx];

	always_comb begin
		handled_d = 1'b1;
		rv_d      = psci_pch_pkg::RV_SUCCESS;
		sv_d      = 1'b0;
		core_on_d = core_on_q;
		unique case (function_id)
			psci_pch_pkg::FN_VERSION: rv_d = psci_pch_pkg::RV_VERSION;
			psci_pch_pkg::FN_CPU_ON_32, psci_pch_pkg::FN_CPU_ON_64: begin
				if (!target_ok) begin
					rv_d = psci_pch_pkg::RV_INVALID;
				end else if (target_on) begin
					rv_d = psci_pch_pkg::RV_ALREADY_ON;
				end else begin
					sv_d                  = 1'b1;
					core_on_d[target_idx] = 1'b1;
				end
			end
			psci_pch_pkg::FN_CPU_OFF: begin
				if (caller_ok) core_on_d[caller_idx] = 1'b0;
			end
			psci_pch_pkg::FN_AFF_INFO_32, psci_pch_pkg::FN_AFF_INFO_64: begin
				if (!target_ok) begin
					rv_d = psci_pch_pkg::RV_INVALID;
				end else begin
					rv_d = target_on ? psci_pch_pkg::RV_AFF_ON : psci_pch_pkg::RV_AFF_OFF;
				end
			end
			psci_pch_pkg::FN_SYS_OFF, psci_pch_pkg::FN_SYS_RESET:
				rv_d = psci_pch_pkg::RV_SUCCESS;
			psci_pch_pkg::FN_FEATURES: begin
				rv_d = psci_pch_pkg::feature_known(argument_one) ?
					psci_pch_pkg::RV_SUCCESS : psci_pch_pkg::RV_NOT_SUPP;
			end
			psci_pch_pkg::FN_MIGRATE_TYPE: rv_d = psci_pch_pkg::RV_MIGRATE;
			default: begin
				handled_d = 1'b0;
				rv_d      = $signed({1'b0, function_id});
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cores_q <= psci_pch_pkg::NUM_CORES_RST;
			core_on_q   <= MAX_CORES'(1);
		end else begin
			if (cfg_wr_en) num_cores_q <= cfg_wr_data;
			if (cmd.load) core_on_q <= core_on_d;
		end
	end

	// Result beat register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			handled_q <= handled_d;
			rv_q      <= rv_d;
			sv_q      <= sv_d;
			sc_q      <= sv_d ? target[psci_pch_pkg::CORE_W-1:0] : '0;
			se_q      <= sv_d ? entry_address : '0;
			sx_q      <= sv_d ? context_value : '0;
		end
	end

	assign handled       = handled_q;
	assign return_value  = rv_q;
	assign start_valid   = sv_q;
	assign start_core    = sc_q;
	assign start_entry   = se_q;
	assign start_context = sx_q;

endmodule

`default_nettype wire

// ===== design/psci_power_call_handler_core.sv =====
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    function_id caller_core argument_one
//                                             entry_address context_value
// out       source     out_valid / out_stall  handled return_value start_valid
//                                             start_core start_entry start_context
// cfg       sink       cfg_wr_en              cfg_wr_data (num_cores)
//
// Decode and the core-on flag update happen at the accept edge,
// and the result beat shows on the next cycle from the output register.
// A new call is taken every cycle unless the output register is full and stalled.
// Reset: core 0 on, all others off; core count 1; output empty.
// The call's entry and context are carried only on the start request.
`default_nettype none

module psci_power_call_handler_core #(
	parameter int MAX_CORES = psci_pch_pkg::MAX_CORES_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [psci_pch_pkg::NUM_CORES_W-1:0]   cfg_wr_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [psci_pch_pkg::FID_W-1:0]         function_id,
	input  wire logic [psci_pch_pkg::CORE_W-1:0]        caller_core,
	input  wire logic [psci_pch_pkg::FID_W-1:0]         argument_one,
	input  wire logic [psci_pch_pkg::ADDR_W-1:0]        entry_address,
	input  wire logic [psci_pch_pkg::ADDR_W-1:0]        context_value,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        handled,
	output logic signed [psci_pch_pkg::RV_W-1:0]        return_value,
	output logic                                        start_valid,
	output logic [psci_pch_pkg::CORE_W-1:0]             start_core,
	output logic [psci_pch_pkg::ADDR_W-1:0]             start_entry,
	output logic [psci_pch_pkg::ADDR_W-1:0]             start_context
);

	psci_pch_pkg::psci_cmd_t cmd;

	psci_pch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	psci_pch_dp #(
		.MAX_CORES (MAX_CORES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.function_id   (function_id),
		.caller_core   (caller_core),
		.argument_one  (argument_one),
		.entry_address (entry_address),
		.context_value (context_value),
		.handled       (handled),
		.return_value  (return_value),
		.start_valid   (start_valid),
		.start_core    (start_core),
		.start_entry   (start_entry),
		.start_context (start_context)
	);

`include "psci_power_call_handler_core_assert.svh"

	`PSCI_ASSERT_NOW(a_start_is_success, clk, arst_n, out_valid && start_valid, handled && (return_value == psci_pch_pkg::RV_SUCCESS), "start request without a successful call")
	`PSCI_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall, out_valid, "input stalled with empty output register")
	`PSCI_ASSERT_NEXT(a_accept_fills, clk, arst_n, in_valid && !in_stall, out_valid, "accepted call produced no result beat")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLDOFF_CYCLES = 64;
	localparam int TAIL_CYCLES    = 4;

	typedef struct packed {
		logic                                 handled;
		logic signed [psci_pch_pkg::RV_W-1:0] rv;
		logic                                 start_valid;
		logic [psci_pch_pkg::CORE_W-1:0]      start_core;
		logic [psci_pch_pkg::ADDR_W-1:0]      start_entry;
		logic [psci_pch_pkg::ADDR_W-1:0]      start_context;
	} psci_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [psci_pch_pkg::NUM_CORES_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [psci_pch_pkg::FID_W-1:0] function_id;
	logic [psci_pch_pkg::CORE_W-1:0] caller_core;
	logic [psci_pch_pkg::FID_W-1:0] argument_one;
	logic [psci_pch_pkg::ADDR_W-1:0] entry_address;
	logic [psci_pch_pkg::ADDR_W-1:0] context_value;
	logic out_valid;
	logic out_stall;
	logic handled;
	logic signed [psci_pch_pkg::RV_W-1:0] return_value;
	logic start_valid;
	logic [psci_pch_pkg::CORE_W-1:0] start_core;
	logic [psci_pch_pkg::ADDR_W-1:0] start_entry;
	logic [psci_pch_pkg::ADDR_W-1:0] start_context;

	logic [psci_pch_pkg::MAX_CORES_DEF-1:0] core_powered;
	logic [psci_pch_pkg::NUM_CORES_W-1:0] cores_configured;
	psci_reply_t pending_replies[$];
	int unsigned fail_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit holdoff_req;

	psci_power_call_handler_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.function_id   (function_id),
		.caller_core   (caller_core),
		.argument_one  (argument_one),
		.entry_address (entry_address),
		.context_value (context_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.handled       (handled),
		.return_value  (return_value),
		.start_valid   (start_valid),
		.start_core    (start_core),
		.start_entry   (start_entry),
		.start_context (start_context)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic psci_reply_t predict_reply(input logic [psci_pch_pkg::FID_W-1:0] fid,
			input logic [psci_pch_pkg::CORE_W-1:0] caller,
			input logic [psci_pch_pkg::FID_W-1:0] arg1,
			input logic [psci_pch_pkg::ADDR_W-1:0] entry,
			input logic [psci_pch_pkg::ADDR_W-1:0] ctx);
		psci_reply_t r;
		logic [psci_pch_pkg::AFF_W-1:0] target;
		int limit;
		r = '0;
		r.handled = 1'b1;
		target = arg1[psci_pch_pkg::AFF_W-1:0];
		limit = (cores_configured > psci_pch_pkg::MAX_CORES_DEF) ?
			psci_pch_pkg::MAX_CORES_DEF : int'(cores_configured);
		case (fid)
			psci_pch_pkg::FN_VERSION: r.rv = psci_pch_pkg::RV_VERSION;
			psci_pch_pkg::FN_CPU_ON_32, psci_pch_pkg::FN_CPU_ON_64: begin
				if (target >= limit)
					r.rv = psci_pch_pkg::RV_INVALID;
				else if (core_powered[target[psci_pch_pkg::CORE_W-1:0]])
					r.rv = psci_pch_pkg::RV_ALREADY_ON;
				else begin
					core_powered[target[psci_pch_pkg::CORE_W-1:0]] = 1'b1;
					r.rv = psci_pch_pkg::RV_SUCCESS;
					r.start_valid = 1'b1;
					r.start_core = target[psci_pch_pkg::CORE_W-1:0];
					r.start_entry = entry;
					r.start_context = ctx;
				end
			end
			psci_pch_pkg::FN_CPU_OFF: begin
				core_powered[caller] = 1'b0;
				r.rv = psci_pch_pkg::RV_SUCCESS;
			end
			psci_pch_pkg::FN_AFF_INFO_32, psci_pch_pkg::FN_AFF_INFO_64: begin
				if (target >= limit)
					r.rv = psci_pch_pkg::RV_INVALID;
				else
					r.rv = core_powered[target[psci_pch_pkg::CORE_W-1:0]] ?
						psci_pch_pkg::RV_AFF_ON : psci_pch_pkg::RV_AFF_OFF;
			end
			psci_pch_pkg::FN_SYS_OFF, psci_pch_pkg::FN_SYS_RESET:
				r.rv = psci_pch_pkg::RV_SUCCESS;
			psci_pch_pkg::FN_FEATURES: begin
				case (arg1)
					psci_pch_pkg::FN_VERSION, psci_pch_pkg::FN_CPU_ON_32,
					psci_pch_pkg::FN_CPU_ON_64, psci_pch_pkg::FN_CPU_OFF,
					psci_pch_pkg::FN_AFF_INFO_32, psci_pch_pkg::FN_AFF_INFO_64,
					psci_pch_pkg::FN_SYS_OFF, psci_pch_pkg::FN_SYS_RESET,
					psci_pch_pkg::FN_FEATURES: r.rv = psci_pch_pkg::RV_SUCCESS;
					default: r.rv = psci_pch_pkg::RV_NOT_SUPP;
				endcase
			end
			psci_pch_pkg::FN_MIGRATE_TYPE: r.rv = psci_pch_pkg::RV_MIGRATE;
			default: begin
				r.handled = 1'b0;
				r.rv = {1'b0, fid};
			end
		endcase
		return r;
	endfunction

	function automatic logic [psci_pch_pkg::FID_W-1:0] pick_psci_fid();
		case ($urandom_range(9))
			0: return psci_pch_pkg::FN_VERSION;
			1: return psci_pch_pkg::FN_CPU_OFF;
			2: return psci_pch_pkg::FN_CPU_ON_32;
			3: return psci_pch_pkg::FN_CPU_ON_64;
			4: return psci_pch_pkg::FN_AFF_INFO_32;
			5: return psci_pch_pkg::FN_AFF_INFO_64;
			6: return psci_pch_pkg::FN_MIGRATE_TYPE;
			7: return psci_pch_pkg::FN_SYS_OFF;
			8: return psci_pch_pkg::FN_SYS_RESET;
			default: return psci_pch_pkg::FN_FEATURES;
		endcase
	endfunction

	task automatic log_failure(input string what, input psci_reply_t want,
			input psci_reply_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t %s", $realtime, what);
			$display("  expected handled=%0b rv=%h start=%0b core=%0d entry=%h ctx=%h",
				want.handled, want.rv, want.start_valid, want.start_core,
				want.start_entry, want.start_context);
			$display("  actual   handled=%0b rv=%h start=%0b core=%0d entry=%h ctx=%h",
				got.handled, got.rv, got.start_valid, got.start_core,
				got.start_entry, got.start_context);
		end
	endtask

	task automatic send_call(input logic [psci_pch_pkg::FID_W-1:0] fid,
			input logic [psci_pch_pkg::CORE_W-1:0] caller,
			input logic [psci_pch_pkg::FID_W-1:0] arg1,
			input logic [psci_pch_pkg::ADDR_W-1:0] entry,
			input logic [psci_pch_pkg::ADDR_W-1:0] ctx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		function_id <= fid;
		caller_core <= caller;
		argument_one <= arg1;
		entry_address <= entry;
		context_value <= ctx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_replies.push_back(predict_reply(fid, caller, arg1, entry, ctx));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_core_count(input logic [psci_pch_pkg::NUM_CORES_W-1:0] count);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cores_configured = count;
	endtask

	task automatic random_call();
		logic [psci_pch_pkg::FID_W-1:0] fid;
		logic [psci_pch_pkg::FID_W-1:0] arg1;
		logic [psci_pch_pkg::CORE_W-1:0] caller;
		int unsigned pick;
		pick = $urandom_range(99);
		caller = psci_pch_pkg::CORE_W'($urandom);
		arg1 = $urandom;
		if ($urandom_range(3) != 0)
			arg1[psci_pch_pkg::AFF_W-1:0] = psci_pch_pkg::AFF_W'($urandom_range(0, 9));
		if (pick < 30)
			fid = $urandom_range(1) ? psci_pch_pkg::FN_CPU_ON_64 : psci_pch_pkg::FN_CPU_ON_32;
		else if (pick < 45)
			fid = psci_pch_pkg::FN_CPU_OFF;
		else if (pick < 62)
			fid = $urandom_range(1) ?
				psci_pch_pkg::FN_AFF_INFO_64 : psci_pch_pkg::FN_AFF_INFO_32;
		else if (pick < 72) begin
			fid = psci_pch_pkg::FN_FEATURES;
			if ($urandom_range(1))
				arg1 = pick_psci_fid();
		end else if (pick < 76)
			fid = psci_pch_pkg::FN_VERSION;
		else if (pick < 79)
			fid = psci_pch_pkg::FN_SYS_OFF;
		else if (pick < 82)
			fid = psci_pch_pkg::FN_SYS_RESET;
		else if (pick < 85)
			fid = psci_pch_pkg::FN_MIGRATE_TYPE;
		else if (pick < 93)
			fid = pick_psci_fid() ^ (32'h1 << $urandom_range(31));
		else
			fid = $urandom;
		send_call(fid, caller, arg1, {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic test_decode_basics();
		send_call(psci_pch_pkg::FN_VERSION, 3'd0, '0, '0, '0);
		send_call(psci_pch_pkg::FN_SYS_OFF, 3'd1, '1, '1, '1);
		send_call(psci_pch_pkg::FN_SYS_RESET, 3'd7, '0, '0, '0);
		send_call(psci_pch_pkg::FN_MIGRATE_TYPE, 3'd0, '0, '0, '0);
		send_call(psci_pch_pkg::FN_FEATURES, 3'd0, psci_pch_pkg::FN_FEATURES, '0, '0);
		send_call(psci_pch_pkg::FN_FEATURES, 3'd0, psci_pch_pkg::FN_CPU_ON_64, '0, '0);
		send_call(psci_pch_pkg::FN_FEATURES, 3'd0, psci_pch_pkg::FN_MIGRATE_TYPE, '0, '0);
		send_call(psci_pch_pkg::FN_FEATURES, 3'd0, '1, '0, '0);
		send_call('0, 3'd0, '0, '0, '0);
		send_call('1, 3'd7, '1, '1, '1);
	endtask

	task automatic test_cpu_on_off();
		send_call(psci_pch_pkg::FN_CPU_ON_32, 3'd0, 32'd0, 64'h1000, 64'h2000);
		send_call(psci_pch_pkg::FN_CPU_ON_32, 3'd0, 32'd1, 64'h1000, 64'h2000);
		send_call(psci_pch_pkg::FN_AFF_INFO_32, 3'd0, 32'hFFFF_FF00, '0, '0);
		send_call(psci_pch_pkg::FN_CPU_OFF, 3'd0, '0, '0, '0);
		send_call(psci_pch_pkg::FN_AFF_INFO_64, 3'd5, 32'd0, '0, '0);
		send_call(psci_pch_pkg::FN_CPU_ON_64, 3'd2, 32'hABCD_EF00, '1, '1);
		send_call(psci_pch_pkg::FN_CPU_OFF, 3'd7, '0, '0, '0);
	endtask

	task automatic test_core_count_limits();
		write_core_count(4'd15);
		send_call(psci_pch_pkg::FN_CPU_ON_32, 3'd0, 32'd7, '0, '1);
		send_call(psci_pch_pkg::FN_AFF_INFO_32, 3'd0, 32'd8, '0, '0);
		send_call(psci_pch_pkg::FN_AFF_INFO_64, 3'd0, 32'hFF, '0, '0);
		write_core_count(4'd0);
		send_call(psci_pch_pkg::FN_CPU_ON_64, 3'd0, 32'd0, '1, '0);
		send_call(psci_pch_pkg::FN_AFF_INFO_32, 3'd0, 32'd0, '0, '0);
		write_core_count(4'd8);
		send_call(psci_pch_pkg::FN_CPU_OFF, 3'd7, '0, '0, '0);
		send_call(psci_pch_pkg::FN_AFF_INFO_32, 3'd0, 32'd7, '0, '0);
		write_core_count(4'd1);
	endtask

	task automatic test_output_holdoff();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_core_count(4'd8);
		holdoff_req = 1'b1;
		repeat (16) random_call();
		wait_drained();
		repeat (8) random_call();
		wait_drained();
	endtask

	task automatic test_random_calls(input int unsigned count, input int unsigned send_pct,
			input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 110 == 0)
				write_core_count(psci_pch_pkg::NUM_CORES_W'($urandom_range(0, 15)));
			random_call();
		end
	endtask

	initial begin : receiver
		int unsigned held;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				held = 0;
				while (held < HOLDOFF_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
					held++;
				end
				holdoff_req = 1'b0;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_replies
		psci_reply_t want;
		psci_reply_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{handled, return_value, start_valid, start_core, start_entry,
				start_context};
			if (pending_replies.size() == 0)
				log_failure("reply beat with nothing outstanding", '0, got);
			else begin
				want = pending_replies.pop_front();
				if (got.handled !== want.handled || got.rv !== want.rv ||
						got.start_valid !== want.start_valid ||
						got.start_core !== want.start_core ||
						got.start_entry !== want.start_entry ||
						got.start_context !== want.start_context)
					log_failure("reply mismatch", want, got);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("psci_power_call_handler_core regression: fail");
		$finish;
	end

	initial begin
		core_powered = 8'b0000_0001;
		cores_configured = psci_pch_pkg::NUM_CORES_RST;
		fail_count = 0;
		send_idle_pct = 26;
		recv_stall_pct = 62;
		holdoff_req = 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		function_id <= '0;
		caller_core <= '0;
		argument_one <= '0;
		entry_address <= '0;
		context_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decode_basics();
		test_cpu_on_off();
		test_core_count_limits();
		test_output_holdoff();
		test_random_calls(540, 26, 62);
		test_random_calls(540, 62, 26);
		test_random_calls(540, 0, 0);
		wait_drained();
		while (pending_replies.size() != 0)
			log_failure("reply never arrived", pending_replies.pop_front(), '0);
		if (fail_count == 0)
			$display("psci_power_call_handler_core regression: pass");
		else
			$display("psci_power_call_handler_core regression: fail");
		$finish;
	end
endmodule

// ===== psci_power_call_handler_core.f =====
+incdir+design
design/psci_pch_pkg.sv
design/psci_pch_ctrl.sv
design/psci_pch_dp.sv
design/psci_power_call_handler_core.sv
tb/sv/tb.sv
